### rtl/csf_pkg.sv
package csf_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_DATA
	} csf_state_t;

	localparam logic REG_STRUCT_LEN = 1'b0;
	localparam logic REG_SLICE_LEN  = 1'b1;

	localparam logic [7:0]  CRC_INIT       = 8'hFF;
	localparam logic [7:0]  CRC_POLY       = 8'h31;
	localparam logic [15:0] STRUCT_LEN_RST = 16'd256;
	localparam logic [6:0]  SLICE_LEN_RST  = 7'd64;

	typedef struct packed {
		logic accept;
		logic load_hdr;
		logic load_data;
	} csf_cmd_t;

	typedef struct packed {
		logic slice_full;
		logic last_data;
	} csf_sts_t;

	function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		int k;
		c = crc ^ b;
		for (k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/csf_in_if.sv
interface csf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

### rtl/csf_out_if.sv
interface csf_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  slice_byte;
	logic [15:0] slice_number;
	logic        slice_end;
	logic        frame_end;

	modport source(output valid, output slice_byte, output slice_number,
		output slice_end, output frame_end, input ready);
	modport sink(input valid, input slice_byte, input slice_number,
		input slice_end, input frame_end, output ready);
endinterface

### rtl/csf_ram.sv
module csf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/csf_ctrl.sv
module csf_ctrl
	import csf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  csf_sts_t sts,
	output csf_cmd_t cmd
);

	csf_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && sts.slice_full) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR: begin
				if (cmd.load_hdr) begin
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (cmd.load_data && sts.last_data) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.load_hdr  = 1'b0;
		cmd.load_data = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_HDR:  cmd.load_hdr = slot_free;
			ST_DATA: cmd.load_data = slot_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_hdr || cmd.load_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/csf_datapath.sv
module csf_datapath
	import csf_pkg::*;
#(
	parameter int MAX_SLICE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic [7:0]  data_byte,
	input  csf_cmd_t    cmd,
	output csf_sts_t    sts,
	output logic [7:0]  slice_byte,
	output logic [15:0] slice_number,
	output logic        slice_end,
	output logic        frame_end
);

	localparam int FW    = $clog2(MAX_SLICE_BYTES);
	localparam int Depth = MAX_SLICE_BYTES - 1;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam logic [6:0] MaxLen = 7'(MAX_SLICE_BYTES);

	logic [15:0]   struct_len_q;
	logic [6:0]    slice_len_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    crc_q;
	logic [15:0]   pos_q;
	logic [15:0]   slice_q;
	logic [FW-1:0] idx_q;

	logic [6:0]    slen_clamp;
	logic [FW-1:0] cap;
	logic [FW-1:0] cap_m1;
	logic [15:0]   slen_eff;
	logic [FW-1:0] fill_inc;
	logic [15:0]   pos_inc;
	logic [FW-1:0] idx_inc;
	logic          frame_done;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	always_comb begin
		if (slice_len_q < 7'd2) begin
			slen_clamp = 7'd2;
		end else if (slice_len_q > MaxLen) begin
			slen_clamp = MaxLen;
		end else begin
			slen_clamp = slice_len_q;
		end
	end

	assign cap        = FW'(slen_clamp - 7'd1);
	assign cap_m1     = FW'(slen_clamp - 7'd2);
	assign slen_eff   = (struct_len_q == 16'd0) ? 16'd1 : struct_len_q;
	assign fill_inc   = fill_q + FW'(1);
	assign pos_inc    = pos_q + 16'd1;
	assign idx_inc    = idx_q + FW'(1);
	assign frame_done = pos_q >= slen_eff;

	assign sts.slice_full = (fill_inc >= cap) || (pos_inc >= slen_eff);
	assign sts.last_data  = idx_q == cap_m1;

	assign ram_re    = cmd.load_hdr || (cmd.load_data && !sts.last_data);
	assign ram_raddr = cmd.load_hdr ? '0 : idx_inc[AW-1:0];

	csf_ram #(
		.WIDTH(8),
		.DEPTH(Depth)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept),
		.waddr(fill_q[AW-1:0]),
		.wdata(data_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			struct_len_q <= STRUCT_LEN_RST;
			slice_len_q  <= SLICE_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRUCT_LEN: struct_len_q <= cfg_wdata;
				REG_SLICE_LEN:  slice_len_q  <= cfg_wdata[6:0];
				default:        struct_len_q <= struct_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			crc_q   <= CRC_INIT;
			pos_q   <= '0;
			slice_q <= '0;
			idx_q   <= '0;
		end else if (cfg_we) begin
			fill_q  <= '0;
			crc_q   <= CRC_INIT;
			pos_q   <= '0;
			slice_q <= '0;
		end else if (cmd.accept) begin
			fill_q <= fill_inc;
			crc_q  <= crc8_update(crc_q, data_byte);
			pos_q  <= pos_inc;
		end else if (cmd.load_hdr) begin
			idx_q <= '0;
		end else if (cmd.load_data) begin
			idx_q <= idx_inc;
			if (sts.last_data) begin
				fill_q <= '0;
				crc_q  <= CRC_INIT;
				if (frame_done) begin
					pos_q   <= '0;
					slice_q <= '0;
				end else begin
					slice_q <= slice_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hdr) begin
			slice_byte   <= crc_q;
			slice_number <= slice_q;
			slice_end    <= 1'b0;
			frame_end    <= 1'b0;
		end else if (cmd.load_data) begin
			slice_byte   <= (idx_q < fill_q) ? ram_rdata : 8'h00;
			slice_number <= slice_q;
			slice_end    <= sts.last_data;
			frame_end    <= sts.last_data && frame_done;
		end
	end

endmodule

### rtl/crc_slice_framer_unit.sv
// Channel   Direction  Payload                                          Role
// in_ch     sink       data_byte                                        structure bytes
// out_ch    source     slice_byte, slice_number, slice_end, frame_end   slice bytes
// cfg       write      cfg_we, cfg_index, cfg_wdata                     lengths
//
// A full slice carries N = slice_length - 1 data bytes: N input transfers, one per cycle,
// then N+1 output transfers, one per cycle while the sink is ready.
// A short final slice is padded, so it still emits N+1 bytes after fewer input transfers.
// Reset clears all control state and loads the length registers; the store is not cleared.
// Input is held off while a slice is emitted, which sets the rate; an output stall holds
// the output register and pauses the emission without losing a byte.
module crc_slice_framer_unit
	import csf_pkg::*;
#(
	parameter int MAX_SLICE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	csf_in_if.sink      in_ch,
	csf_out_if.source   out_ch
);

	csf_cmd_t cmd;
	csf_sts_t sts;

	csf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csf_datapath #(
		.MAX_SLICE_BYTES(MAX_SLICE_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.data_byte   (in_ch.data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.slice_byte  (out_ch.slice_byte),
		.slice_number(out_ch.slice_number),
		.slice_end   (out_ch.slice_end),
		.frame_end   (out_ch.frame_end)
	);

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_hdr, cmd.load_data}))
		else $error("controller issued overlapping commands");

	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_hdr |=> out_ch.valid && !out_ch.slice_end && !out_ch.frame_end)
		else $error("header byte flagged as end of slice");

	a_last_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_data && sts.last_data |=> out_ch.valid && out_ch.slice_end)
		else $error("final slice byte missing its end flag");

	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_hdr || cmd.load_data |-> !in_ch.ready)
		else $error("input taken during slice emission");

endmodule

### dv/crc_slice_framer_unit_test.sv
`timescale 1ns / 1ps

module crc_slice_framer_unit_test;
	import csf_pkg::*;

	localparam int SLICE_BYTES_MAX = 64;
	localparam int STORE_DEPTH = SLICE_BYTES_MAX - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_BYTES = 300;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0]  slice_byte;
		logic [15:0] slice_number;
		logic        slice_end;
		logic        frame_end;
	} slice_beat_t;

	typedef struct packed {
		logic       known;
		logic [7:0] value;
	} header_note_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_BYTE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        reg_sel;
		logic [15:0] value;
		logic        hdr_known;
		logic [7:0]  hdr;
	} stim_row_t;

	// A header over the single byte 0xFF is zero, since it cancels the initial value.
	localparam stim_row_t DIRECTED_ROWS [28] = '{
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0000, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h00FF, 1'b0, 8'h00},
		'{ROW_WRITE, REG_SLICE_LEN,  16'd2,    1'b0, 8'h00},
		'{ROW_WRITE, REG_STRUCT_LEN, 16'd3,    1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h00FF, 1'b1, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0000, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0080, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h00FF, 1'b1, 8'h00},
		'{ROW_WRITE, REG_STRUCT_LEN, 16'd0,    1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h00FF, 1'b1, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0001, 1'b0, 8'h00},
		'{ROW_WRITE, REG_SLICE_LEN,  16'd0,    1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0055, 1'b0, 8'h00},
		'{ROW_WRITE, REG_SLICE_LEN,  16'd1,    1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h00AA, 1'b0, 8'h00},
		'{ROW_WRITE, REG_SLICE_LEN,  16'hFFFF, 1'b0, 8'h00},
		'{ROW_WRITE, REG_STRUCT_LEN, 16'd5,    1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0001, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0002, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0004, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0008, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0010, 1'b0, 8'h00},
		'{ROW_WRITE, REG_STRUCT_LEN, 16'hFFFF, 1'b0, 8'h00},
		'{ROW_WRITE, REG_SLICE_LEN,  16'd3,    1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0020, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h0040, 1'b0, 8'h00},
		'{ROW_BYTE,  REG_STRUCT_LEN, 16'h00FE, 1'b0, 8'h00},
		'{ROW_WRITE, REG_SLICE_LEN,  16'h0041, 1'b0, 8'h00}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	csf_in_if  in_ch();
	csf_out_if out_ch();

	crc_slice_framer_unit #(
		.MAX_SLICE_BYTES(SLICE_BYTES_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [15:0] struct_len;
	logic [6:0]  slice_len;
	logic [7:0]  held_bytes [STORE_DEPTH];
	logic [5:0]  fill_ct;
	logic [7:0]  crc_acc;
	logic [15:0] byte_pos;
	logic [15:0] slice_idx;

	slice_beat_t  slice_beats_due [$];
	header_note_t header_notes [$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int calm_items = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] d);
		logic [7:0] r;
		logic fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ d[i];
			r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	task automatic restart_structure();
		fill_ct = '0;
		crc_acc = CRC_INIT;
		byte_pos = '0;
		slice_idx = '0;
	endtask

	task automatic apply_register(logic sel, logic [15:0] val);
		if (sel == REG_STRUCT_LEN) begin
			struct_len = val;
		end else begin
			slice_len = val[6:0];
		end
		restart_structure();
	endtask

	task automatic take_structure_byte(logic [7:0] b, header_note_t note);
		int cap;
		int limit;
		logic done;
		slice_beat_t beat;
		if (slice_len < 2) begin
			cap = 1;
		end else if (slice_len > SLICE_BYTES_MAX) begin
			cap = SLICE_BYTES_MAX - 1;
		end else begin
			cap = slice_len - 1;
		end
		limit = (struct_len == 0) ? 1 : struct_len;
		if (fill_ct < STORE_DEPTH) begin
			held_bytes[fill_ct] = b;
		end
		crc_acc = crc8_next(crc_acc, b);
		fill_ct = fill_ct + 6'd1;
		byte_pos = byte_pos + 16'd1;
		done = (byte_pos >= limit);
		if (fill_ct >= cap || done) begin
			beat.slice_byte = note.known ? note.value : crc_acc;
			beat.slice_number = slice_idx;
			beat.slice_end = 1'b0;
			beat.frame_end = 1'b0;
			slice_beats_due.push_back(beat);
			for (int i = 0; i < cap; i++) begin
				beat.slice_byte = (i < fill_ct) ? held_bytes[i] : 8'h00;
				beat.slice_end = (i == cap - 1);
				beat.frame_end = (i == cap - 1) && done;
				slice_beats_due.push_back(beat);
			end
			fill_ct = '0;
			crc_acc = CRC_INIT;
			if (done) begin
				byte_pos = '0;
				slice_idx = '0;
			end else begin
				slice_idx = slice_idx + 16'd1;
			end
		end
	endtask

	task automatic report_mismatch(string what, slice_beat_t want, slice_beat_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%s: expected %02h/%0d/%b/%b, got %02h/%0d/%b/%b", what,
				want.slice_byte, want.slice_number, want.slice_end, want.frame_end,
				got.slice_byte, got.slice_number, got.slice_end, got.frame_end);
		end
	endtask

	always @(posedge clk) begin
		header_note_t note;
		slice_beat_t got;
		slice_beat_t want;
		if (!arst_n) begin
			struct_len = STRUCT_LEN_RST;
			slice_len = SLICE_LEN_RST;
			restart_structure();
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (cfg_we) begin
				apply_register(cfg_index, cfg_wdata);
				quiet_cycles = 0;
			end
			if (in_ch.valid && in_ch.ready) begin
				note = '0;
				if (header_notes.size() != 0) begin
					note = header_notes.pop_front();
				end
				take_structure_byte(in_ch.data_byte, note);
				quiet_cycles = 0;
			end
			if (out_ch.valid && out_ch.ready) begin
				quiet_cycles = 0;
				got.slice_byte = out_ch.slice_byte;
				got.slice_number = out_ch.slice_number;
				got.slice_end = out_ch.slice_end;
				got.frame_end = out_ch.frame_end;
				if (slice_beats_due.size() == 0) begin
					report_mismatch("unexpected slice byte", '0, got);
				end else begin
					want = slice_beats_due.pop_front();
					if (got !== want) begin
						report_mismatch("slice byte mismatch", want, got);
					end
				end
			end
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int run;
		logic calm;
		out_ch.ready <= 1'b0;
		forever begin
			run = $urandom_range(1, 40);
			calm = ($urandom_range(0, 3) == 0);
			repeat (run) begin
				@(posedge clk);
				out_ch.ready <= calm || ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				@(posedge clk);
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(8, 30)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_items = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 25);
	endfunction

	task automatic send_byte(logic [7:0] b, logic hdr_known, logic [7:0] hdr);
		int gap;
		header_note_t note;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note.known = hdr_known;
		note.value = hdr;
		header_notes.push_back(note);
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_register(logic sel, logic [15:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (slice_beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int n;
		int eff;
		int pick;
		int which;
		logic [6:0] slice_val;
		logic [15:0] struct_now;
		logic [15:0] struct_word;
		logic [7:0] b;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_STRUCT_LEN;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		struct_now = STRUCT_LEN_RST;
		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
				write_register(DIRECTED_ROWS[i].reg_sel, DIRECTED_ROWS[i].value);
				if (DIRECTED_ROWS[i].reg_sel == REG_STRUCT_LEN) begin
					struct_now = DIRECTED_ROWS[i].value;
				end
			end else begin
				send_byte(DIRECTED_ROWS[i].value[7:0], DIRECTED_ROWS[i].hdr_known,
					DIRECTED_ROWS[i].hdr);
			end
		end

		// Each phase mostly sends whole structures; some leave one open for the next write.
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				slice_val = 7'($urandom_range(0, 2));
			end else if (pick == 1) begin
				slice_val = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
			end else if (pick < 7) begin
				slice_val = 7'($urandom_range(2, 9));
			end else begin
				slice_val = 7'($urandom_range(10, 63));
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				struct_word = 16'($urandom_range(0, 1));
			end else if (pick == 1) begin
				struct_word = 16'hFFFF;
			end else if (pick == 2) begin
				struct_word = 16'($urandom_range(41, 400));
			end else begin
				struct_word = 16'($urandom_range(1, 40));
			end
			which = $urandom_range(0, 3);
			if (which != 1) begin
				write_register(REG_STRUCT_LEN, struct_word);
				struct_now = struct_word;
			end
			if (which != 0) begin
				write_register(REG_SLICE_LEN, {9'($urandom), slice_val});
			end
			eff = (struct_now == 0) ? 1 : struct_now;
			if (eff > 120) begin
				n = $urandom_range(20, 150);
			end else begin
				n = eff * $urandom_range(1, 3);
				if (n > 150) begin
					n = eff;
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				n += $urandom_range(1, 5);
			end
			if (n > RANDOM_BYTES - sent) begin
				n = RANDOM_BYTES - sent;
			end
			repeat (n) begin
				pick = $urandom_range(0, 15);
				if (pick == 0) begin
					b = 8'h00;
				end else if (pick == 1) begin
					b = 8'hFF;
				end else begin
					b = 8'($urandom);
				end
				send_byte(b, 1'b0, 8'h00);
			end
			sent += n;
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (slice_beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && slice_beats_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
rtl/csf_pkg.sv
rtl/csf_in_if.sv
rtl/csf_out_if.sv
rtl/csf_ram.sv
rtl/csf_ctrl.sv
rtl/csf_datapath.sv
rtl/crc_slice_framer_unit.sv
dv/crc_slice_framer_unit_test.sv
